>>> sv/lws_pkg.sv
package lws_pkg;

    // register map, index of each register (byte address is 4 * index)
    localparam logic [2:0] REG_PERIOD       = 3'd0;
    localparam logic [2:0] REG_RATE_SCALE   = 3'd1;
    localparam logic [2:0] REG_PHASE_OFFSET = 3'd2;
    localparam logic [2:0] REG_WAVE_SELECT  = 3'd3;
    localparam logic [2:0] REG_DEPTH_AMOUNT = 3'd4;
    localparam logic [2:0] REG_CENTER_BASE  = 3'd5;

    // register reset values
    localparam logic [31:0] PERIOD_RST = 32'h0001_0000;
    localparam logic [31:0] DEPTH_RST  = 32'h0001_0000;

    // rate scale codes
    localparam logic [1:0] RATE_X1     = 2'd0;
    localparam logic [1:0] RATE_X100   = 2'd1;
    localparam logic [1:0] RATE_DIV100 = 2'd2;

    // wave codes
    localparam logic [2:0] WAVE_SINE   = 3'd0;
    localparam logic [2:0] WAVE_TRI    = 3'd1;
    localparam logic [2:0] WAVE_SAW    = 3'd2;
    localparam logic [2:0] WAVE_SQUARE = 3'd3;
    localparam logic [2:0] WAVE_MOOG   = 3'd4;
    localparam logic [2:0] WAVE_PULSE  = 3'd5;
    localparam logic [2:0] WAVE_RANDOM = 3'd6;

    // divider sizes: dividend is the scaled time shifted up by 16 fraction bits
    localparam int DIV_NUM_W = 55;
    localparam int DIV_DEN_W = 39;
    localparam int DIV_CNT_W = 6;
    localparam int FRAC_W    = 16;

    // shared multiplier operand widths
    localparam int MUL_A_W = 20;
    localparam int MUL_B_W = 33;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // reciprocal of 45 scaled by 2^30, used as p * 64 / 45 = p * M / 2^24
    localparam logic [32:0] RECIP_45 = 33'd23860930;
    // reciprocal of 5 scaled by 2^22
    localparam logic [32:0] RECIP_5  = 33'd838861;
    // pulse mirror point, 0.51 in Q0.16
    localparam logic [15:0] PULSE_KNEE = 16'd33423;

    typedef struct packed {
        logic [31:0] period;
        logic [1:0]  rate_scale;
        logic [15:0] phase_offset;
        logic [2:0]  wave_select;
        logic [31:0] depth_amount;
        logic [31:0] center_base;
    } t_cfg;

    typedef struct packed {
        logic                  start;
        logic [DIV_NUM_W-1:0]  num;
        logic [DIV_DEN_W-1:0]  den;
        logic [DIV_CNT_W-1:0]  steps;
    } t_div_req;

    // triangle in Q2.16 for phase x in Q0.16
    function automatic logic signed [19:0] f_tri(input logic [15:0] x);
        logic               neg;
        logic [15:0]        xs;
        logic signed [17:0] d;
        logic [14:0]        mag;
        logic [16:0]        u;
        logic [16:0]        r;
        neg = (x > 16'd32768);
        xs  = neg ? (x - 16'd32768) : x;
        d   = $signed({2'b00, xs}) - 18'sd16384;
        mag = d[17] ? 15'(-d) : 15'(d);
        u   = {mag, 2'b00};
        r   = 17'h10000 - u;
        return neg ? -$signed({3'b000, r}) : $signed({3'b000, r});
    endfunction

endpackage

>>> sv/lws_regs.sv
module lws_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output lws_pkg::t_cfg     o_cfg
);

    logic [31:0] r_period;
    logic [1:0]  r_rate_scale;
    logic [15:0] r_phase_offset;
    logic [2:0]  r_wave_select;
    logic [31:0] r_depth_amount;
    logic [31:0] r_center_base;
    logic        wr_en;
    logic [2:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period       <= lws_pkg::PERIOD_RST;
            r_rate_scale   <= lws_pkg::RATE_X1;
            r_phase_offset <= '0;
            r_wave_select  <= lws_pkg::WAVE_SINE;
            r_depth_amount <= lws_pkg::DEPTH_RST;
            r_center_base  <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                lws_pkg::REG_PERIOD:       r_period       <= pwdata;
                lws_pkg::REG_RATE_SCALE:   r_rate_scale   <= pwdata[1:0];
                lws_pkg::REG_PHASE_OFFSET: r_phase_offset <= pwdata[15:0];
                lws_pkg::REG_WAVE_SELECT:  r_wave_select  <= pwdata[2:0];
                lws_pkg::REG_DEPTH_AMOUNT: r_depth_amount <= pwdata;
                lws_pkg::REG_CENTER_BASE:  r_center_base  <= pwdata;
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (reg_idx)
            lws_pkg::REG_PERIOD:       prdata = r_period;
            lws_pkg::REG_RATE_SCALE:   prdata = {30'd0, r_rate_scale};
            lws_pkg::REG_PHASE_OFFSET: prdata = {16'd0, r_phase_offset};
            lws_pkg::REG_WAVE_SELECT:  prdata = {29'd0, r_wave_select};
            lws_pkg::REG_DEPTH_AMOUNT: prdata = r_depth_amount;
            lws_pkg::REG_CENTER_BASE:  prdata = r_center_base;
            default:                   prdata = 32'd0;
        endcase
    end

    assign o_cfg.period       = r_period;
    assign o_cfg.rate_scale   = r_rate_scale;
    assign o_cfg.phase_offset = r_phase_offset;
    assign o_cfg.wave_select  = r_wave_select;
    assign o_cfg.depth_amount = r_depth_amount;
    assign o_cfg.center_base  = r_center_base;

endmodule

>>> sv/lws_divider.sv
module lws_divider (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lws_pkg::t_div_req            i_req,
    output logic                         o_done,
    output logic [lws_pkg::FRAC_W-1:0]   o_quo
);

    logic [lws_pkg::DIV_NUM_W-1:0] r_num;
    logic [lws_pkg::DIV_DEN_W-1:0] r_den;
    logic [lws_pkg::DIV_DEN_W-1:0] r_rem;
    logic [lws_pkg::FRAC_W-1:0]    r_quo;
    logic [lws_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;

    logic [lws_pkg::DIV_DEN_W:0]   trial;
    logic [lws_pkg::DIV_DEN_W:0]   diff;
    logic                          fits;
    logic [lws_pkg::DIV_DEN_W-1:0] n_rem;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_num[lws_pkg::DIV_NUM_W-1]};
        diff  = trial - {1'b0, r_den};
        fits  = (trial >= {1'b0, r_den});
        n_rem = fits ? diff[lws_pkg::DIV_DEN_W-1:0] : trial[lws_pkg::DIV_DEN_W-1:0];
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // done pulses for one cycle after the last step
            r_done <= !i_req.start && r_busy && (r_cnt == 1);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[lws_pkg::DIV_NUM_W-2:0], 1'b0};
            r_rem <= n_rem;
            r_quo <= {r_quo[lws_pkg::FRAC_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

>>> sv/lws_multiplier.sv
module lws_multiplier (
    input  logic                                 i_clk,
    input  logic signed [lws_pkg::MUL_A_W-1:0]   i_a,
    input  logic signed [lws_pkg::MUL_B_W-1:0]   i_b,
    output logic signed [lws_pkg::MUL_P_W-1:0]   o_p
);

    logic signed [lws_pkg::MUL_P_W-1:0] r_p;

    // registered signed product
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

>>> sv/lfo_waveform_sampler.sv
// LFO waveform sampler: each time beat (unsigned Q16.16 seconds) yields one
// lfo_value beat (signed Q16.16, wave * depth_amount + center_base, saturated).
// The phase time/period is formed by a bit-serial divider that retires one
// quotient bit per clock: 48 steps for rate scale x1 or /100, 55 for x100.
// A single shared 20x33 multiplier serves the start phase, the wave shape
// (up to three passes) and the output gain. The input is not ready while an
// item is in work. The result sits in an output register, so the next time
// beat is taken as soon as the result is loaded there. Registers sit on the
// APB port at byte address 4 * index and should only be written while the
// block is idle.
module lfo_waveform_sampler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] time_seconds
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] lfo_value
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PHASE = 4'd1;
    localparam logic [3:0] S_DIVW  = 4'd2;
    localparam logic [3:0] S_WAVE  = 4'd3;
    localparam logic [3:0] S_SINE  = 4'd4;
    localparam logic [3:0] S_MOOG  = 4'd5;
    localparam logic [3:0] S_PULSE = 4'd6;
    localparam logic [3:0] S_RAND  = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;
    localparam logic [3:0] S_OUTP  = 4'd9;

    localparam logic [lws_pkg::DIV_CNT_W-1:0] STEPS_SHORT = lws_pkg::DIV_CNT_W'(48);
    localparam logic [lws_pkg::DIV_CNT_W-1:0] STEPS_LONG  =
        lws_pkg::DIV_CNT_W'(lws_pkg::DIV_NUM_W);

    lws_pkg::t_cfg     cfg;
    lws_pkg::t_div_req div_req;
    logic              div_done;
    logic [15:0]       div_quo;

    logic signed [lws_pkg::MUL_A_W-1:0] mul_a;
    logic signed [lws_pkg::MUL_B_W-1:0] mul_b;
    logic signed [lws_pkg::MUL_P_W-1:0] mul_p;

    logic [3:0]         r_state;
    logic [15:0]        r_xph;
    logic [15:0]        r_x;
    logic               r_neg;
    logic signed [19:0] r_w;
    logic [1:0]         r_pcnt;
    logic [31:0]        r_step;
    logic [31:0]        r_sum;
    logic [31:0]        r_sum2;
    logic               r_out_valid;
    logic [31:0]        r_out_data;

    logic               in_acc;
    logic               out_free;
    logic [31:0]        t_in;
    logic [38:0]        t100;
    logic [38:0]        p100;

    logic               half_neg;
    logic [15:0]        half_x;
    logic signed [17:0] sine_d;
    logic signed [17:0] sine_u;
    logic [16:0]        sine_sq;
    logic [16:0]        sine_r;
    logic [16:0]        moog_x;
    logic [18:0]        moog_n;
    logic [16:0]        pulse_x;
    logic [16:0]        pulse_v0;
    logic [18:0]        pulse_vn;
    logic [31:0]        n_step;
    logic [31:0]        n_sum;
    logic [31:0]        n_sum2;
    logic [31:0]        rnd_mix;
    logic [7:0]         rnd_byte;
    logic signed [9:0]  rnd_k;
    logic signed [19:0] rnd_kw;
    logic signed [19:0] rnd_w;
    logic signed [36:0] out_sh;
    logic signed [37:0] out_sum;
    logic [31:0]        out_sat;

    lws_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lws_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    lws_multiplier u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // handshakes
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc          = i_s_axis_tvalid && (r_state == S_IDLE);
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // times-hundred by shift and add
    assign t_in = i_s_axis_tdata;
    assign t100 = ({7'd0, t_in} << 6) + ({7'd0, t_in} << 5) + ({7'd0, t_in} << 2);
    assign p100 = ({7'd0, cfg.period} << 6) + ({7'd0, cfg.period} << 5)
                + ({7'd0, cfg.period} << 2);

    // divider request, dividend left aligned with 16 fraction bits below
    always_comb begin
        div_req.start = in_acc;
        case (cfg.rate_scale)
            lws_pkg::RATE_X100: begin
                div_req.num   = {t100, 16'd0};
                div_req.den   = {7'd0, cfg.period};
                div_req.steps = STEPS_LONG;
            end
            lws_pkg::RATE_DIV100: begin
                div_req.num   = {t_in, 23'd0};
                div_req.den   = p100;
                div_req.steps = STEPS_SHORT;
            end
            default: begin
                div_req.num   = {t_in, 23'd0};
                div_req.den   = {7'd0, cfg.period};
                div_req.steps = STEPS_SHORT;
            end
        endcase
    end

    // wave shaping helpers
    always_comb begin
        half_neg = (r_x > 16'd32768);
        half_x   = half_neg ? (r_x - 16'd32768) : r_x;
        sine_d   = $signed({2'b00, half_x}) - 18'sd16384;
        sine_u   = $signed({sine_d[15:0], 2'b00});
        sine_sq  = mul_p[32:16];
        sine_r   = 17'h10000 - sine_sq;

        moog_x   = (r_x > 16'd16384) ? ({1'b0, r_x} + 17'd16384) : {1'b0, r_x};
        moog_n   = {moog_x, 2'b00};

        pulse_x  = (r_x > lws_pkg::PULSE_KNEE) ? (17'h10000 - {1'b0, r_x}) : {1'b0, r_x};
        pulse_v0 = {pulse_x[15:0], 1'b0};
        pulse_vn = mul_p[34:16];

        n_step   = r_step + 32'd1;
        n_sum    = r_sum + n_step;
        n_sum2   = r_sum2 + n_sum;
        rnd_mix  = ({r_step[30:0], 1'b0} + r_step) + ({r_sum[29:0], 2'b00} + r_sum)
                 + ({r_sum2[28:0], 3'b000} - r_sum2);
        rnd_byte = rnd_mix[13:6];
        rnd_k    = $signed({1'b0, rnd_byte, 1'b0}) - 10'sd255;
        rnd_kw   = {{10{rnd_k[9]}}, rnd_k};
        // k * 65536 / 255 = 257 k, plus one toward the sign when |k| is 255
        if (rnd_byte == 8'hFF) begin
            rnd_w = (rnd_kw <<< 8) + rnd_kw + 20'sd1;
        end else if (rnd_byte == 8'h00) begin
            rnd_w = (rnd_kw <<< 8) + rnd_kw - 20'sd1;
        end else begin
            rnd_w = (rnd_kw <<< 8) + rnd_kw;
        end
    end

    // output floor shift, offset and saturation
    always_comb begin
        out_sh  = mul_p[52:16];
        out_sum = {out_sh[36], out_sh} + {{6{cfg.center_base[31]}}, cfg.center_base};
        if (out_sum[37:31] == 7'h00 || out_sum[37:31] == 7'h7F) begin
            out_sat = out_sum[31:0];
        end else begin
            out_sat = out_sum[37] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = r_w;
        mul_b = {cfg.depth_amount[31], cfg.depth_amount};
        case (r_state)
            S_IDLE: begin
                mul_a = {4'd0, cfg.phase_offset};
                mul_b = lws_pkg::RECIP_45;
            end
            S_WAVE: begin
                case (cfg.wave_select)
                    lws_pkg::WAVE_SINE: begin
                        mul_a = {{2{sine_u[17]}}, sine_u};
                        mul_b = {{15{sine_u[17]}}, sine_u};
                    end
                    lws_pkg::WAVE_MOOG: begin
                        mul_a = {1'b0, moog_n};
                        mul_b = lws_pkg::RECIP_5;
                    end
                    lws_pkg::WAVE_PULSE: begin
                        mul_a = {3'd0, pulse_v0};
                        mul_b = {16'd0, pulse_v0};
                    end
                    default: ;
                endcase
            end
            S_PULSE: begin
                mul_a = {1'b0, pulse_vn};
                mul_b = {14'd0, pulse_vn};
            end
            default: ;
        endcase
    end

    // output register: loading a new beat wins over the old beat leaving
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUTP && out_free) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_sum       <= '0;
            r_sum2      <= '0;
            r_pcnt      <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_PHASE;
                    end
                end
                S_PHASE: begin
                    // start phase = offset * 64 / 45, modulo one turn
                    r_xph   <= mul_p[39:24];
                    r_state <= S_DIVW;
                end
                S_DIVW: begin
                    if (div_done) begin
                        r_x     <= ((cfg.period == 32'd0) ? 16'd0 : div_quo) + r_xph;
                        r_state <= S_WAVE;
                    end
                end
                S_WAVE: begin
                    r_neg <= half_neg;
                    case (cfg.wave_select)
                        lws_pkg::WAVE_SINE: begin
                            r_state <= S_SINE;
                        end
                        lws_pkg::WAVE_TRI: begin
                            r_w     <= lws_pkg::f_tri(r_x);
                            r_state <= S_OUT;
                        end
                        lws_pkg::WAVE_SAW: begin
                            r_w     <= ($signed({4'd0, r_x}) - 20'sd32768) <<< 1;
                            r_state <= S_OUT;
                        end
                        lws_pkg::WAVE_SQUARE: begin
                            r_w     <= (r_x > 16'd32768) ? -20'sd65536 : 20'sd65536;
                            r_state <= S_OUT;
                        end
                        lws_pkg::WAVE_MOOG: begin
                            r_state <= S_MOOG;
                        end
                        lws_pkg::WAVE_PULSE: begin
                            r_pcnt  <= '0;
                            r_state <= S_PULSE;
                        end
                        lws_pkg::WAVE_RANDOM: begin
                            r_step  <= n_step;
                            r_sum   <= n_sum;
                            r_sum2  <= n_sum2;
                            r_state <= S_RAND;
                        end
                        default: begin
                            r_w     <= '0;
                            r_state <= S_OUT;
                        end
                    endcase
                end
                S_SINE: begin
                    r_w     <= r_neg ? -$signed({3'd0, sine_r}) : $signed({3'd0, sine_r});
                    r_state <= S_OUT;
                end
                S_MOOG: begin
                    // (4x) / 5 by reciprocal, then the triangle
                    r_w     <= lws_pkg::f_tri(mul_p[37:22]);
                    r_state <= S_OUT;
                end
                S_PULSE: begin
                    // three squarings, the later ones fed back from the product
                    if (r_pcnt == 2'd2) begin
                        r_w     <= 20'($signed({1'b0, pulse_vn, 1'b0}) - 21'sd65536);
                        r_state <= S_OUT;
                    end else begin
                        r_pcnt <= r_pcnt + 2'd1;
                    end
                end
                S_RAND: begin
                    r_w     <= rnd_w;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_state <= S_OUTP;
                end
                S_OUTP: begin
                    if (out_free) begin
                        r_out_data  <= out_sat;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int            CLK_HALF     = 10;
    localparam longint        TIMEOUT_NS   = 64'd20_000_000;
    localparam longint        Q_ONE        = 65536;
    localparam longint        Q_HALF       = 32768;
    localparam longint        Q_QUARTER    = 16384;
    localparam longint        S32_MAX      = 64'sd2147483647;
    localparam longint        S32_MIN      = -64'sd2147483648;
    localparam longint unsigned PHASE_TURN = 46080;
    localparam logic [2:0]    WAVE_ZERO    = 3'd7;
    localparam logic [1:0]    RATE_X1_ALT  = 2'd3;

    // dut connections, every input known from time zero
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata  = '0;   // [31:0] time_seconds
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;         // [31:0] lfo_value
    logic        psel            = 1'b0;
    logic        penable         = 1'b0;
    logic        pwrite          = 1'b0;
    logic [4:0]  paddr           = '0;
    logic [31:0] pwdata          = '0;
    logic [31:0] prdata;
    logic        pready;

    // register shadow and random accumulators
    lws_pkg::t_cfg lfo_cfg;
    logic [31:0]   rand_step = '0;
    logic [31:0]   rand_sum  = '0;
    logic [31:0]   rand_sum2 = '0;

    logic [31:0] lfo_expected[$];

    // idling controls
    bit tx_gaps      = 1'b0;
    bit rx_gaps      = 1'b0;
    bit rx_hold      = 1'b0;
    int hold_request = 0;
    int rx_stall     = 0;

    int err_count      = 0;
    int n_items        = 0;
    int n_results      = 0;
    int n_settings     = 0;
    int n_random_reads = 0;
    int n_saturated    = 0;

    lfo_waveform_sampler i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // wave shapes in Q2.16 for phase x in Q0.16
    // ---------------------------------------------------------------
    function automatic longint tri_wave(input longint xp);
        longint xs;
        longint u;
        bit     neg;
        xs  = xp;
        neg = 1'b0;
        if (xs > Q_HALF) begin
            xs  = xs - Q_HALF;
            neg = 1'b1;
        end
        u = (xs - Q_QUARTER) * 4;
        if (u < 0) u = -u;
        u = Q_ONE - u;
        return neg ? -u : u;
    endfunction

    function automatic longint sine_wave(input longint xp);
        longint xs;
        longint u;
        longint r;
        bit     neg;
        xs  = xp;
        neg = 1'b0;
        if (xs > Q_HALF) begin
            xs  = xs - Q_HALF;
            neg = 1'b1;
        end
        u = (xs - Q_QUARTER) * 4;
        r = Q_ONE - ((u * u) >>> 16);
        return neg ? -r : r;
    endfunction

    function automatic longint pulse_wave(input longint xp);
        longint          xs;
        longint unsigned v;
        xs = xp;
        // mirrored above the 0.51 knee
        if (xs > longint'(lws_pkg::PULSE_KNEE)) xs = Q_ONE - xs;
        v = xs * 2;
        v = (v * v) >> 16;
        v = (v * v) >> 16;
        v = (v * v) >> 16;
        return longint'(v) * 2 - Q_ONE;
    endfunction

    // accumulators move only on a random wave read
    function automatic longint random_wave();
        logic [31:0] mix;
        longint      r;
        rand_step = rand_step + 32'd1;
        rand_sum  = rand_sum + rand_step;
        rand_sum2 = rand_sum2 + rand_sum;
        mix = rand_step * 32'd3 + rand_sum * 32'd5 + rand_sum2 * 32'd7;
        r   = longint'(mix[13:6]);
        n_random_reads++;
        return ((r * 2 - 255) * Q_ONE) / 255;
    endfunction

    // lfo value for one time beat under the current registers
    function automatic logic [31:0] predict_lfo(input logic [31:0] t);
        longint unsigned num;
        longint unsigned den;
        longint unsigned frac_rate;
        longint unsigned frac_phase;
        longint          x;
        longint          w;
        longint          y;
        num = {32'd0, t};
        den = {32'd0, lfo_cfg.period};
        if (lfo_cfg.rate_scale == lws_pkg::RATE_X100) num = num * 100;
        else if (lfo_cfg.rate_scale == lws_pkg::RATE_DIV100) den = den * 100;
        // zero period contributes no rate phase
        frac_rate = 0;
        if (den != 0) frac_rate = ((num % den) << 16) / den;
        frac_phase = (({48'd0, lfo_cfg.phase_offset} % PHASE_TURN) << 16) / PHASE_TURN;
        x = longint'((frac_rate + frac_phase) & 64'hFFFF);
        case (lfo_cfg.wave_select)
            lws_pkg::WAVE_SINE:   w = sine_wave(x);
            lws_pkg::WAVE_TRI:    w = tri_wave(x);
            lws_pkg::WAVE_SAW:    w = (x - Q_HALF) * 2;
            lws_pkg::WAVE_SQUARE: w = (x > Q_HALF) ? -Q_ONE : Q_ONE;
            lws_pkg::WAVE_MOOG: begin
                if (x > Q_QUARTER) x = x + Q_QUARTER;
                w = tri_wave((x * 4) / 5);
            end
            lws_pkg::WAVE_PULSE:  w = pulse_wave(x);
            lws_pkg::WAVE_RANDOM: w = random_wave();
            WAVE_ZERO:            w = 0;
            default:              w = 0;
        endcase
        y = ((w * longint'($signed(lfo_cfg.depth_amount))) >>> 16)
            + longint'($signed(lfo_cfg.center_base));
        if (y > S32_MAX) begin
            y = S32_MAX;
            n_saturated++;
        end else if (y < S32_MIN) begin
            y = S32_MIN;
            n_saturated++;
        end
        return y[31:0];
    endfunction

    // ---------------------------------------------------------------
    // result side: compare each beat, random stalls and long hold
    // ---------------------------------------------------------------
    task automatic check_lfo(input logic [31:0] got);
        logic [31:0] want;
        n_results++;
        if (lfo_expected.size() == 0) begin
            err_count++;
            if (err_count <= 10)
                $display("unexpected result %0d: got %h", n_results, got);
            return;
        end
        want = lfo_expected.pop_front();
        if (got !== want) begin
            err_count++;
            if (err_count <= 10)
                $display("mismatch lfo_value at result %0d: expected %h got %h",
                         n_results, want, got);
        end
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && i_m_axis_tready && o_m_axis_tvalid) check_lfo(o_m_axis_tdata);
            if (rx_hold) begin
                i_m_axis_tready <= 1'b0;
            end else if (rx_stall > 0) begin
                i_m_axis_tready <= 1'b0;
                rx_stall--;
            end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
                i_m_axis_tready <= 1'b0;
                rx_stall = $urandom_range(0, 2);
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // long receiver hold, counted here
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                rx_hold <= 1'b1;
                repeat (hold_request) @(posedge i_clk);
                rx_hold <= 1'b0;
                hold_request = 0;
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    task automatic send_time(input logic [31:0] t);
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= t;
        do @(posedge i_clk); while (!o_s_axis_tready);
        lfo_expected.push_back(predict_lfo(t));
        n_items++;
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (lfo_expected.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // setup then access; psel stays high between back-to-back writes
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            lws_pkg::REG_PERIOD:       lfo_cfg.period       = value;
            lws_pkg::REG_RATE_SCALE:   lfo_cfg.rate_scale   = value[1:0];
            lws_pkg::REG_PHASE_OFFSET: lfo_cfg.phase_offset = value[15:0];
            lws_pkg::REG_WAVE_SELECT:  lfo_cfg.wave_select  = value[2:0];
            lws_pkg::REG_DEPTH_AMOUNT: lfo_cfg.depth_amount = value;
            lws_pkg::REG_CENTER_BASE:  lfo_cfg.center_base  = value;
            default: ;
        endcase
    endtask

    task automatic set_lfo(input logic [31:0] period, input logic [1:0] rate,
                           input logic [15:0] phase, input logic [2:0] wave,
                           input logic [31:0] depth, input logic [31:0] base);
        write_reg(lws_pkg::REG_PERIOD, period);
        write_reg(lws_pkg::REG_RATE_SCALE, {30'd0, rate});
        write_reg(lws_pkg::REG_PHASE_OFFSET, {16'd0, phase});
        write_reg(lws_pkg::REG_WAVE_SELECT, {29'd0, wave});
        write_reg(lws_pkg::REG_DEPTH_AMOUNT, depth);
        write_reg(lws_pkg::REG_CENTER_BASE, base);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        n_settings++;
    endtask

    function automatic logic [31:0] pick_time();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0:       v = $urandom_range(0, 32'h0010_0000);
            1:       v = 32'hFFFF_FFFF - $urandom_range(0, 255);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // signed Q16.16 gain or offset, mostly near unity, sometimes extreme
    function automatic logic [31:0] pick_q16();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0:       v = 32'h7FFF_FFFF;
            1:       v = 32'h8000_0000;
            2:       v = $urandom;
            default: begin
                v = $urandom_range(0, 32'h0004_0000);
                v = v - 32'h0002_0000;
            end
        endcase
        return v;
    endfunction

    task automatic random_settings();
        logic [31:0] period;
        logic [15:0] phase;
        logic [2:0]  wave;
        case ($urandom_range(0, 9))
            0:       period = 32'd1;
            1:       period = 32'hFFFF_FFFF;
            2:       period = 32'd0;
            3, 4, 5, 6: period = $urandom_range(32'h0000_1000, 32'h0008_0000);
            default: period = $urandom;
        endcase
        case ($urandom_range(0, 9))
            0:       phase = 16'd0;
            1:       phase = 16'd46079;
            2:       phase = 16'hFFFF;
            default: phase = 16'($urandom_range(0, 16'hFFFF));
        endcase
        wave = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 3) == 0) wave = lws_pkg::WAVE_RANDOM;
        set_lfo(period, 2'($urandom_range(0, 3)), phase, wave, pick_q16(), pick_q16());
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------
    task automatic test_reset_values();
        send_time(32'd0);
        send_time(32'h0000_4000);
        send_time(32'hFFFF_FFFF);
    endtask

    task automatic test_wave_shapes();
        logic [2:0] wave_code;
        wave_code = lws_pkg::WAVE_SINE;
        repeat (8) begin
            drain_results();
            set_lfo(lws_pkg::PERIOD_RST, lws_pkg::RATE_X1, 16'd0, wave_code,
                    lws_pkg::DEPTH_RST, 32'd0);
            send_time(32'h0000_2000);
            send_time(32'h0000_A000);
            wave_code++;
        end
    endtask

    task automatic test_special_cases();
        // zero period leaves only the start phase
        drain_results();
        set_lfo(32'd0, lws_pkg::RATE_X1, 16'd11520, lws_pkg::WAVE_SAW,
                lws_pkg::DEPTH_RST, 32'd0);
        send_time(32'h1234_5678);
        // rate code 3 behaves as times one
        drain_results();
        set_lfo(32'h0003_0000, RATE_X1_ALT, 16'd0, lws_pkg::WAVE_TRI,
                lws_pkg::DEPTH_RST, 32'd0);
        send_time(32'h0002_8000);
        // start phase past a full turn wraps
        drain_results();
        set_lfo(lws_pkg::PERIOD_RST, lws_pkg::RATE_X1, 16'hFFFF, lws_pkg::WAVE_SINE,
                lws_pkg::DEPTH_RST, 32'h0000_8000);
        send_time(32'h0000_1000);
        // widest dividend, then the smallest scaled divisor
        drain_results();
        set_lfo(32'hFFFF_FFFF, lws_pkg::RATE_X100, 16'd46079, lws_pkg::WAVE_MOOG,
                lws_pkg::DEPTH_RST, 32'd0);
        send_time(32'hFFFF_FFFF);
        drain_results();
        set_lfo(32'd1, lws_pkg::RATE_DIV100, 16'd0, lws_pkg::WAVE_PULSE,
                lws_pkg::DEPTH_RST, 32'd0);
        send_time(32'h0000_0033);
    endtask

    task automatic test_saturation();
        drain_results();
        set_lfo(lws_pkg::PERIOD_RST, lws_pkg::RATE_X1, 16'd0, lws_pkg::WAVE_SQUARE,
                32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_time(32'd0);
        send_time(32'h0000_C000);
        drain_results();
        set_lfo(lws_pkg::PERIOD_RST, lws_pkg::RATE_X1, 16'd0, lws_pkg::WAVE_SQUARE,
                32'h8000_0000, 32'h8000_0000);
        send_time(32'd0);
    endtask

    // receiver holds off while the sender keeps offering beats
    task automatic test_backpressure();
        drain_results();
        random_settings();
        tx_gaps = 1'b0;
        rx_gaps = 1'b1;
        hold_request = 400;
        repeat (15) send_time(pick_time());
    endtask

    task automatic test_random_settings();
        repeat (13) begin
            drain_results();
            random_settings();
            tx_gaps = ($urandom_range(0, 2) != 0);
            rx_gaps = ($urandom_range(0, 2) != 0);
            repeat (25) send_time(pick_time());
        end
    endtask

    // back-to-back traffic with no idling on either side
    task automatic test_steady_stream();
        repeat (2) begin
            drain_results();
            tx_gaps = 1'b0;
            rx_gaps = 1'b0;
            random_settings();
            repeat (20) send_time(pick_time());
        end
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin
        lfo_cfg.period       = lws_pkg::PERIOD_RST;
        lfo_cfg.rate_scale   = lws_pkg::RATE_X1;
        lfo_cfg.phase_offset = 16'd0;
        lfo_cfg.wave_select  = lws_pkg::WAVE_SINE;
        lfo_cfg.depth_amount = lws_pkg::DEPTH_RST;
        lfo_cfg.center_base  = 32'd0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_wave_shapes();
        test_special_cases();
        test_saturation();
        test_backpressure();
        test_random_settings();
        test_steady_stream();

        drain_results();
        repeat (80) @(posedge i_clk);

        $display("checked %0d lfo values from %0d time beats over %0d register settings",
                 n_results, n_items, n_settings);
        $display("%0d random wave reads, %0d saturated outputs", n_random_reads, n_saturated);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // run limit
    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results still expected", lfo_expected.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
